// ===== rtl/core/ffba_pkg.sv =====
// shared types, codes and defaults of the first-fit block allocator
package ffba_pkg;

    // field widths
    localparam int ADDR_W   = 20;
    localparam int STATUS_W = 2;

    // parameter defaults and register reset value
    localparam int                DEF_MAX_BLOCKS   = 64;
    localparam int                DEF_HEADER_BYTES = 24;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 20'hFFFFF;

    // operation codes carried in tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NULL      = 2'd1,
        ST_OOM       = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // one block table entry as read back
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } entry_t;

    // block table write request
    typedef struct packed {
        logic              en;    // write the free flag
        logic              full;  // also write start and size
        logic              free;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } tbl_wr_t;

    // one result item
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } result_t;

endpackage

// ===== rtl/core/ffba_table.sv =====
// block table memory: one write port, one registered read port
module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_BLOCKS
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output entry_t                   rd_data,
    input  tbl_wr_t                  wr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr
);

    logic [ADDR_W-1:0] start_mem [DEPTH];
    logic [ADDR_W-1:0] size_mem  [DEPTH];
    logic              free_mem  [DEPTH];
    entry_t            rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            free_mem[wr_addr] <= wr.free;
            if (wr.full) begin
                start_mem[wr_addr] <= wr.start;
                size_mem[wr_addr]  <= wr.size;
            end
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.start <= start_mem[rd_addr];
            rd_data_reg.size  <= size_mem[rd_addr];
            rd_data_reg.free  <= free_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ffba_ctrl.sv =====
// sequencer, table walk with shared compare unit, and heap bookkeeping
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request side
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    input  logic [ADDR_W-1:0]             in_size,
    input  logic [ADDR_W-1:0]             in_addr,
    input  logic [ADDR_W-1:0]             heap_limit,
    // block table
    output logic                          tbl_rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0] tbl_rd_addr,
    input  entry_t                        tbl_rd_data,
    output tbl_wr_t                       tbl_wr,
    output logic [$clog2(MAX_BLOCKS)-1:0] tbl_wr_addr,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]   top_reg, top_next;
    logic                func_reg;
    logic [ADDR_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W:0]     payload_reg;
    logic                null_reg;
    logic [CW-1:0]       idx_reg;
    logic                pend_reg;
    logic [IW-1:0]       pidx_reg;
    logic                found_reg;
    logic [IW-1:0]       fidx_reg;
    logic [ADDR_W-1:0]   fstart_reg;

    logic                in_fire;
    logic                in_null;
    logic                issue;
    logic                match;
    logic                hit;
    logic                scan_end;
    logic [ADDR_W+1:0]   new_top;
    logic                oom;
    logic                is_last;
    logic                res_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_null  = (in_func == FUNC_ALLOC) ? (in_size == '0) : (in_addr == '0);
    assign res_fire = res_valid && res_ready;

    // table walk: one read issued per cycle, compare on the entry read the cycle before
    assign issue       = (state_reg == S_SCAN) && (idx_reg < count_reg);
    assign tbl_rd_en   = issue;
    assign tbl_rd_addr = idx_reg[IW-1:0];

    // shared compare unit: fit test for allocate, address match for free
    assign match = (func_reg == FUNC_ALLOC) ?
                   (tbl_rd_data.free && (tbl_rd_data.size >= size_reg)) :
                   (tbl_rd_data.start == addr_reg);
    assign hit      = pend_reg && match;
    assign scan_end = (state_reg == S_SCAN) && (hit || !issue);

    // append check and top-block test
    assign new_top = {1'b0, payload_reg} + {2'b00, size_reg};
    assign oom     = (count_reg >= CW'(MAX_BLOCKS)) || (new_top > {2'b00, heap_limit});
    assign is_last = (CW'(fidx_reg) + CW'(1)) == count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = in_null ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result, table update and heap bookkeeping
    always_comb begin
        res_valid   = (state_reg == S_FINISH);
        res.status  = ST_OK;
        res.addr    = '0;
        tbl_wr      = '0;
        tbl_wr_addr = fidx_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        if (state_reg == S_FINISH) begin
            if (null_reg) begin
                res.status = ST_NULL;
            end else if (func_reg == FUNC_ALLOC) begin
                if (found_reg) begin
                    // reuse the first fitting free block as it is
                    res.addr    = fstart_reg;
                    tbl_wr.en   = 1'b1;
                    tbl_wr.free = 1'b0;
                end else if (oom) begin
                    res.status = ST_OOM;
                end else begin
                    // append a new block at the heap top
                    res.addr     = payload_reg[ADDR_W-1:0];
                    tbl_wr.en    = 1'b1;
                    tbl_wr.full  = 1'b1;
                    tbl_wr.free  = 1'b0;
                    tbl_wr.start = payload_reg[ADDR_W-1:0];
                    tbl_wr.size  = size_reg;
                    tbl_wr_addr  = count_reg[IW-1:0];
                    count_next   = CW'(count_reg + CW'(1));
                    top_next     = new_top[ADDR_W-1:0];
                end
            end else begin
                if (!found_reg) begin
                    res.status = ST_NOT_FOUND;
                end else if (is_last) begin
                    // topmost block goes away and the heap shrinks
                    count_next = CW'(count_reg - CW'(1));
                    top_next   = addr_reg - ADDR_W'(HEADER_BYTES);
                end else begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.free = 1'b1;
                end
            end
            // nothing changes until the result beat is taken
            if (!res_fire) begin
                tbl_wr.en  = 1'b0;
                count_next = count_reg;
                top_next   = top_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            if (in_fire) begin
                pend_reg <= 1'b0;
            end else if (state_reg == S_SCAN) begin
                pend_reg <= issue;
            end
        end
    end

    // request capture and walk registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg    <= in_func;
            size_reg    <= in_size;
            addr_reg    <= in_addr;
            null_reg    <= in_null;
            payload_reg <= {1'b0, top_reg} + (ADDR_W + 1)'(HEADER_BYTES);
            idx_reg     <= '0;
            found_reg   <= 1'b0;
        end else if (state_reg == S_SCAN) begin
            if (issue) begin
                idx_reg <= CW'(idx_reg + CW'(1));
            end
            pidx_reg <= idx_reg[IW-1:0];
            if (hit) begin
                found_reg  <= 1'b1;
                fidx_reg   <= pidx_reg;
                fstart_reg <= tbl_rd_data.start;
            end
        end
    end

`ifndef SYNTHESIS
    // table never holds more blocks than it has rows
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count above table depth");

    // an empty table means an empty heap
    a_empty_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (top_reg == '0))
        else $error("heap top not zero with empty table");

    // the table is only written while a result beat is delivered
    a_wr_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.en |-> res_fire)
        else $error("table write outside result beat");

    // block count changes only while a result beat is delivered, by at most one per item
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != count_next) |-> res_fire)
        else $error("block count changed outside result beat");
`endif

endmodule

// ===== rtl/core/first_fit_block_allocator.sv =====
// First-fit block allocator over a heap of byte offsets. Each request beat
// on s_ (tuser 0 allocate, 1 free) gives exactly one result beat on m_
// (status in tuser, payload offset in tdata). The block table is a memory
// walked one entry per cycle through its single read port; the walk stops
// early when a fitting or matching block is found, and a null request skips
// the walk. s_tready is high only between items; a finished result
// waits in the output register while the next request is taken. The table
// needs no clearing after reset. heap_limit is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,    // heap_limit
    // request stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,      // alloc_size [19:0], free_addr [39:20]
    input  logic              s_tuser,      // func
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,      // block_addr [19:0], zero [23:20]
    output logic [1:0]        m_tuser       // status
);

    localparam int IW = $clog2(MAX_BLOCKS);

    logic [ADDR_W-1:0] heap_limit_reg;
    logic              m_tvalid_reg;
    result_t           m_res_reg;

    logic              tbl_rd_en;
    logic [IW-1:0]     tbl_rd_addr;
    entry_t            tbl_rd_data;
    tbl_wr_t           tbl_wr;
    logic [IW-1:0]     tbl_wr_addr;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    // heap limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= HEAP_LIMIT_RESET;
        end else if (cfg_we) begin
            heap_limit_reg <= cfg_wdata;
        end
    end

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_size     (s_tdata[ADDR_W-1:0]),
        .in_addr     (s_tdata[2*ADDR_W-1:ADDR_W]),
        .heap_limit  (heap_limit_reg),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data),
        .tbl_wr      (tbl_wr),
        .tbl_wr_addr (tbl_wr_addr),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ffba_table #(
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr      (tbl_wr),
        .wr_addr (tbl_wr_addr)
    );

    // output register between the sequencer and the result stream
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_res_reg.addr};
    assign m_tuser  = m_res_reg.status;

endmodule
